@@ rtl/core/fdq_pkg.sv @@
// shared types and constants for the float to dosage quantizer
// no dependencies
`timescale 1ns / 1ps

package fdq_pkg;

    localparam int GROUP_SIZE       = 32;
    localparam int POS_W            = $clog2(GROUP_SIZE);
    localparam int THR_W            = 14;
    localparam int DOSAGE_W         = 16;
    localparam int COUNT_W          = 21;
    localparam int MAX_SAMPLES_DEF  = 1048576;

    localparam logic [1:0]  GENO_NOCALL  = 2'd3;
    localparam logic [13:0] HALF_MID     = 14'd8192;

    // one classified sample travelling from front to back
    typedef struct packed {
        logic [1:0]          geno;
        logic                present;
        logic [DOSAGE_W-1:0] dosage;
        logic                last;
    } fdq_entry_t;

endpackage

@@ rtl/core/float_to_dosage_quantizer.sv @@
// top level of the float to dosage quantizer
// depends on fdq_pkg, fdq_front, fdq_queue, fdq_back
`timescale 1ns / 1ps

// usage
// - input channel s_*: one single precision dosage per transfer, with
//   s_last_sample marking the final sample of a variant
// - result channel m_*: exactly one result per input transfer, in order;
//   packed words ride along when a group of 32 fills or at the last sample
// - hard_call_wr writes the hard call threshold; write it only
//   while no transfer is in flight
// - a sample is classified and queued at the transfer edge, and packed into
//   the output register, which raises m_valid, once that register is empty
//   or being taken by the receiver
// - throughput: one transfer per cycle while s_ready is high; the classify
//   path and the packing path are decoupled by the two entry queue
// - when the receiver stalls the output register holds, the queue fills,
//   and s_ready drops once both queue entries are taken
// - reset clears the threshold, the packs, group position and dosage count

module float_to_dosage_quantizer #(
    parameter int MAX_SAMPLES = fdq_pkg::MAX_SAMPLES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             hard_call_wr,
    input  logic [fdq_pkg::THR_W-1:0]        hard_call_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [31:0]                      s_value_bits,
    input  logic                             s_last_sample,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_geno_code,
    output logic                             m_dosage_flag,
    output logic [fdq_pkg::DOSAGE_W-1:0]     m_dosage_value,
    output logic                             m_word_valid,
    output logic [2*fdq_pkg::GROUP_SIZE-1:0] m_packed_genotypes,
    output logic [fdq_pkg::GROUP_SIZE-1:0]   m_packed_present,
    output logic [fdq_pkg::COUNT_W-1:0]      m_dosage_total,
    output logic                             m_last_out
);
    import fdq_pkg::*;

    logic [THR_W-1:0] thr_reg;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_not_empty;
    fdq_entry_t       q_wdata;
    fdq_entry_t       q_rdata;

    // threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (hard_call_wr) begin
            thr_reg <= hard_call_wdata;
        end
    end

    // decode and classify each incoming transfer
    fdq_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value_bits  (s_value_bits),
        .s_last_sample (s_last_sample),
        .thr           (thr_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_wdata)
    );

    // decoupling queue
    fdq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wdata     (q_wdata),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    // packing, counting and output register
    fdq_back #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_not_empty        (q_not_empty),
        .q_data             (q_rdata),
        .q_pop              (q_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_geno_code        (m_geno_code),
        .m_dosage_flag      (m_dosage_flag),
        .m_dosage_value     (m_dosage_value),
        .m_word_valid       (m_word_valid),
        .m_packed_genotypes (m_packed_genotypes),
        .m_packed_present   (m_packed_present),
        .m_dosage_total     (m_dosage_total),
        .m_last_out         (m_last_out)
    );

endmodule

@@ rtl/core/fdq_front.sv @@
// front part: takes input transfers and classifies each float dosage
// depends on fdq_pkg
`timescale 1ns / 1ps

module fdq_front (
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [31:0]                 s_value_bits,
    input  logic                        s_last_sample,
    input  logic [fdq_pkg::THR_W-1:0]   thr,
    input  logic                        q_full,
    output logic                        q_push,
    output fdq_pkg::fdq_entry_t         q_data
);
    import fdq_pkg::*;

    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [23:0] sig24;
    logic [7:0]  eeff;
    logic [41:0] ext;
    logic [41:0] y_fix;
    logic [41:0] s_fix;
    logic [16:0] ipart;
    logic [24:0] frac;
    logic [16:0] smear;
    logic        rup;
    logic [17:0] dfull;
    logic        big;
    logic        pos_ok;
    logic        neg_zero;
    logic [15:0] d;
    logic [13:0] rem;
    logic [13:0] half;
    logic [15:0] dsum;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        sgn   = s_value_bits[31];
        ex    = s_value_bits[30:23];
        man   = s_value_bits[22:0];
        sig24 = {(ex != 8'd0), man};
        eeff  = (ex == 8'd0) ? 8'd1 : ex;
        ext   = {18'd0, sig24};
        // y = x * 16384 as fixed point with 25 fraction bits
        if (eeff >= 8'd111) begin
            y_fix = ext << 5'(eeff - 8'd111);
        end else begin
            y_fix = ext >> 7'(8'd111 - eeff);
        end
        big   = (eeff > 8'd129);
        s_fix = y_fix + 42'(1 << 24);
        ipart = s_fix[41:25];
        frac  = s_fix[24:0];
        smear = ipart;
        for (int i = 0; i < 5; i++) begin
            smear = smear | (smear >> (1 << i));
        end
        // single precision rounding of y + 0.5 carries into the next integer
        rup      = &(frac | {8'd0, smear});
        dfull    = {1'b0, ipart} + 18'(rup);
        pos_ok   = !sgn && !big && (dfull <= 18'd32768);
        neg_zero = sgn && ((ex < 8'd112) || ((ex == 8'd112) && (man == 23'd0)));
        d        = neg_zero ? 16'd0 : dfull[15:0];
        rem      = d[13:0];
        half     = rem[13] ? {1'b0, rem[12:0]} : (HALF_MID - rem);
        dsum     = d + 16'd8192;

        q_data.last    = s_last_sample;
        q_data.geno    = GENO_NOCALL;
        q_data.present = 1'b0;
        q_data.dosage  = '0;
        if (pos_ok || neg_zero) begin
            if (half >= thr) begin
                q_data.geno = dsum[15:14];
            end
            if (half != HALF_MID) begin
                q_data.present = 1'b1;
                q_data.dosage  = d;
            end
        end
    end

endmodule

@@ rtl/core/fdq_queue.sv @@
// two entry queue between the front and the back
// depends on fdq_pkg
`timescale 1ns / 1ps

module fdq_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  fdq_pkg::fdq_entry_t wdata,
    input  logic                pop,
    output fdq_pkg::fdq_entry_t rdata,
    output logic                not_empty,
    output logic                full
);
    import fdq_pkg::*;

    fdq_entry_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign rdata     = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

@@ rtl/core/fdq_back.sv @@
// back part: packs genotypes and present bits, counts dosages, holds the output register
// depends on fdq_pkg
`timescale 1ns / 1ps

module fdq_back #(
    parameter int MAX_SAMPLES = fdq_pkg::MAX_SAMPLES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_not_empty,
    input  fdq_pkg::fdq_entry_t           q_data,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_geno_code,
    output logic                          m_dosage_flag,
    output logic [fdq_pkg::DOSAGE_W-1:0]  m_dosage_value,
    output logic                          m_word_valid,
    output logic [2*fdq_pkg::GROUP_SIZE-1:0] m_packed_genotypes,
    output logic [fdq_pkg::GROUP_SIZE-1:0]   m_packed_present,
    output logic [fdq_pkg::COUNT_W-1:0]   m_dosage_total,
    output logic                          m_last_out
);
    import fdq_pkg::*;

    localparam longint CAP_FULL = (longint'(MAX_SAMPLES) < ((64'd1 << COUNT_W) - 1)) ?
                                  longint'(MAX_SAMPLES) : ((64'd1 << COUNT_W) - 1);
    localparam logic [COUNT_W-1:0] CAP = COUNT_W'(CAP_FULL);

    logic [2*GROUP_SIZE-1:0] geno_pack_reg,  geno_pack_next;
    logic [GROUP_SIZE-1:0]   pres_pack_reg,  pres_pack_next;
    logic [POS_W-1:0]        pos_reg;
    logic [COUNT_W-1:0]      count_reg,      count_next;
    logic                    valid_reg;
    logic                    emit;

    assign q_pop   = q_not_empty && (!valid_reg || m_ready);
    assign m_valid = valid_reg;

    always_comb begin
        geno_pack_next = geno_pack_reg | ((2*GROUP_SIZE)'(q_data.geno) << {pos_reg, 1'b0});
        pres_pack_next = pres_pack_reg | (GROUP_SIZE'(q_data.present) << pos_reg);
        count_next     = count_reg;
        if (q_data.present && (count_reg < CAP)) begin
            count_next = count_reg + COUNT_W'(1);
        end
        emit = q_data.last || (pos_reg == POS_W'(GROUP_SIZE - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            geno_pack_reg <= '0;
            pres_pack_reg <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
        end else begin
            if (q_pop) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
            if (q_pop) begin
                if (emit) begin
                    geno_pack_reg <= '0;
                    pres_pack_reg <= '0;
                    pos_reg       <= '0;
                end else begin
                    geno_pack_reg <= geno_pack_next;
                    pres_pack_reg <= pres_pack_next;
                    pos_reg       <= pos_reg + POS_W'(1);
                end
                count_reg <= q_data.last ? '0 : count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_geno_code        <= q_data.geno;
            m_dosage_flag      <= q_data.present;
            m_dosage_value     <= q_data.dosage;
            m_word_valid       <= emit;
            m_packed_genotypes <= emit ? geno_pack_next : '0;
            m_packed_present   <= emit ? pres_pack_next : '0;
            m_dosage_total     <= count_next;
            m_last_out         <= q_data.last;
        end
    end

endmodule

@@ rtl/core/fdq_checker.sv @@
// port level checks for the float to dosage quantizer, bound to the top level
// depends on float_to_dosage_quantizer
`timescale 1ns / 1ps

module fdq_props (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_dosage_flag,
    input logic [15:0] m_dosage_value,
    input logic        m_word_valid,
    input logic [63:0] m_packed_genotypes,
    input logic [31:0] m_packed_present,
    input logic        m_last_out
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_packed_genotypes))
        else $error("stalled result changed");

    a_no_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_word_valid |-> m_packed_genotypes == 64'd0 && m_packed_present == 32'd0)
        else $error("packed words nonzero without word_valid");

    a_last_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_out |-> m_word_valid)
        else $error("last sample without packed words");

    a_absent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_dosage_flag |-> m_dosage_value == 16'd0)
        else $error("dosage value without present flag");

endmodule

bind float_to_dosage_quantizer fdq_props u_fdq_props (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_dosage_flag      (m_dosage_flag),
    .m_dosage_value     (m_dosage_value),
    .m_word_valid       (m_word_valid),
    .m_packed_genotypes (m_packed_genotypes),
    .m_packed_present   (m_packed_present),
    .m_last_out         (m_last_out)
);
